// File: hdl/bet_pkg.sv
`timescale 1ns / 1ps
package bet_pkg;

   localparam int MAX_POINTS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DW         = FRAC_BITS + 1;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIV_W      = $clog2(DW);

   localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   localparam logic [1:0] OP_EVAL   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NUDGE  = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_MARGIN    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NO_REMOVE = 2'd3;

   localparam logic [1:0] REG_REMOVE_TOL   = 2'd0;
   localparam logic [1:0] REG_INSERT_MARG  = 2'd1;
   localparam logic [1:0] REG_REMOVE_MARG  = 2'd2;
   localparam logic [1:0] REG_NUDGE_STEP   = 2'd3;

   localparam logic [16:0] RST_REMOVE_TOL  = 17'((64'd655 << FRAC_BITS) >> 16);
   localparam logic [15:0] RST_INSERT_MARG = 16'((64'd1311 << FRAC_BITS) >> 16);
   localparam logic [15:0] RST_REMOVE_MARG = 16'((64'd1638 << FRAC_BITS) >> 16);
   localparam logic [16:0] RST_NUDGE_STEP  = 17'((64'd6554 << FRAC_BITS) >> 16);

   typedef struct packed {
      logic [1:0]    op;
      logic [DW-1:0] position;
      logic [DW-1:0] level;
      logic          nudge_down;
   } req_type;

   typedef struct packed {
      logic [DW-1:0]    value;
      logic [CNT_W-1:0] point_count;
      logic [1:0]       status;
   } rsp_type;

endpackage

// File: hdl/breakpoint_envelope_table.sv
`timescale 1ns / 1ps
// Evaluate walks the table one entry per cycle (up to MAX_POINTS entries), then does one
//   multiply step and a serial restoring divide.
// Insert: one scan pass plus one shift pass over the table.
// Remove: one compaction pass over the table. One request at a time.
// Synchronous reset restores the two end points (0,0), (1,0), count 2 and register defaults.
module breakpoint_envelope_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bet_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bet_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int DW    = bet_pkg::DW;
   localparam int IDX_W = bet_pkg::IDX_W;
   localparam int CNT_W = bet_pkg::CNT_W;
   localparam int DIV_W = bet_pkg::DIV_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EVSCAN = 4'd1;
   localparam logic [3:0] S_EVMUL  = 4'd2;
   localparam logic [3:0] S_EVDIV  = 4'd3;
   localparam logic [3:0] S_EVFIN  = 4'd4;
   localparam logic [3:0] S_INSFND = 4'd5;
   localparam logic [3:0] S_INSSHF = 4'd6;
   localparam logic [3:0] S_REM    = 4'd7;
   localparam logic [3:0] S_NUD0   = 4'd8;
   localparam logic [3:0] S_NUD1   = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [16:0] remove_tol_ff;
   logic [15:0] insert_marg_ff;
   logic [15:0] remove_marg_ff;
   logic [16:0] nudge_step_ff;

   logic [DW-1:0] pos_ff [bet_pkg::MAX_POINTS];
   logic [DW-1:0] lvl_ff [bet_pkg::MAX_POINTS];
   logic [CNT_W-1:0] used_ff;

   logic [3:0]       state_ff;
   bet_pkg::req_type req_ff;
   logic [DW-1:0]    t_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] k_ff;
   logic [IDX_W-1:0] w_ff;
   logic             removed_ff;
   logic [DW-1:0]    prev_p_ff, prev_l_ff, cur_p_ff, cur_l_ff;
   logic [DW-1:0]    span_ff;
   logic             neg_ff;
   logic [DW-1:0]    low_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    quo_ff;
   logic [DIV_W-1:0] div_cnt_ff;
   logic [DW-1:0]    value_ff;
   logic [1:0]       status_ff;
   logic             rsp_valid_ff;
   bet_pkg::rsp_type rsp_ff;

   // register port
   logic csr_wr;
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         bet_pkg::REG_REMOVE_TOL:  prdata = 32'(remove_tol_ff);
         bet_pkg::REG_INSERT_MARG: prdata = 32'(insert_marg_ff);
         bet_pkg::REG_REMOVE_MARG: prdata = 32'(remove_marg_ff);
         bet_pkg::REG_NUDGE_STEP:  prdata = 32'(nudge_step_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remove_tol_ff  <= bet_pkg::RST_REMOVE_TOL;
         insert_marg_ff <= bet_pkg::RST_INSERT_MARG;
         remove_marg_ff <= bet_pkg::RST_REMOVE_MARG;
         nudge_step_ff  <= bet_pkg::RST_NUDGE_STEP;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            bet_pkg::REG_REMOVE_TOL:  remove_tol_ff  <= pwdata[16:0];
            bet_pkg::REG_INSERT_MARG: insert_marg_ff <= pwdata[15:0];
            bet_pkg::REG_REMOVE_MARG: remove_marg_ff <= pwdata[15:0];
            bet_pkg::REG_NUDGE_STEP:  nudge_step_ff  <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   // table read port
   logic [IDX_W-1:0] rd_addr;
   logic [DW-1:0]    rd_pos, rd_lvl;
   logic [IDX_W-1:0] last_idx;
   assign last_idx = IDX_W'(used_ff - CNT_W'(1));
   assign rd_addr  = (state_ff == S_INSSHF) ? idx_ff - IDX_W'(1) : idx_ff;
   assign rd_pos   = pos_ff[rd_addr];
   assign rd_lvl   = lvl_ff[rd_addr];

   // margin tests on the incoming request
   logic [DW-1:0] ins_m, rem_m;
   logic          ins_ok, rem_ok;
   assign ins_m  = DW'(insert_marg_ff);
   assign rem_m  = DW'(remove_marg_ff);
   assign ins_ok = (req_data.position > ins_m) && (req_data.position < bet_pkg::ONE - ins_m);
   assign rem_ok = (req_data.position > rem_m) && (req_data.position < bet_pkg::ONE - rem_m);

   // evaluate helpers
   logic [DW-1:0]   dt_c, span_c, mag_c;
   logic [2*DW-1:0] prod_c;
   assign span_c = cur_p_ff - prev_p_ff;
   assign dt_c   = ((t_ff - prev_p_ff) > span_c) ? span_c : t_ff - prev_p_ff;
   assign mag_c  = (cur_l_ff < prev_l_ff) ? prev_l_ff - cur_l_ff : cur_l_ff - prev_l_ff;
   assign prod_c = mag_c * dt_c;

   logic [DW:0]   trial;
   assign trial = {rem_ff, low_ff[DW-1]};

   logic [DW:0]   fin_sum;
   logic [DW-1:0] fin_val;
   always_comb begin
      fin_sum = neg_ff ? {1'b0, prev_l_ff} - {1'b0, quo_ff} : {1'b0, prev_l_ff} + {1'b0, quo_ff};
      if (fin_sum[DW])
         fin_val = neg_ff ? '0 : bet_pkg::ONE;
      else if (fin_sum[DW-1:0] > bet_pkg::ONE)
         fin_val = bet_pkg::ONE;
      else
         fin_val = fin_sum[DW-1:0];
   end

   // remove window hit
   logic [DW:0] q_plus, p_plus;
   logic        hit;
   assign q_plus = {1'b0, rd_pos} + (DW+1)'(remove_tol_ff);
   assign p_plus = {1'b0, req_ff.position} + (DW+1)'(remove_tol_ff);
   assign hit    = (q_plus > {1'b0, req_ff.position}) && ({1'b0, rd_pos} < p_plus);

   // nudge level
   logic [DW:0]   nud_sum;
   logic [DW-1:0] nud_val;
   always_comb begin
      if (req_ff.nudge_down) begin
         nud_sum = {1'b0, rd_lvl} - (DW+1)'(nudge_step_ff);
         nud_val = nud_sum[DW] ? '0 : nud_sum[DW-1:0];
      end else begin
         nud_sum = {1'b0, rd_lvl} + (DW+1)'(nudge_step_ff);
         nud_val = (nud_sum > (DW+1)'(bet_pkg::ONE)) ? bet_pkg::ONE : nud_sum[DW-1:0];
      end
   end

   logic [DW-1:0] ins_lvl;
   assign ins_lvl = (req_ff.level > bet_pkg::ONE) ? bet_pkg::ONE : req_ff.level;

   logic [IDX_W-1:0] k_new;
   assign k_new = (rd_pos <= req_ff.position) ? idx_ff : k_ff;

   // single table write port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [DW-1:0]    wr_pos, wr_lvl;
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_pos  = rd_pos;
      wr_lvl  = rd_lvl;
      case (state_ff)
         S_INSSHF: begin
            wr_en = 1'b1;
            if ({1'b0, idx_ff} <= {1'b0, k_ff} + (IDX_W+1)'(1)) begin
               wr_pos = req_ff.position;
               wr_lvl = ins_lvl;
            end
         end
         S_REM: begin
            wr_addr = w_ff;
            wr_en   = (idx_ff == last_idx) || !hit;
         end
         S_NUD0, S_NUD1: begin
            wr_en  = 1'b1;
            wr_lvl = nud_val;
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= CNT_W'(2);
         rsp_valid_ff <= 1'b0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= bet_pkg::ONE;
         lvl_ff[0]    <= '0;
         lvl_ff[1]    <= '0;
      end else begin
         if (wr_en) begin
            pos_ff[wr_addr] <= wr_pos;
            lvl_ff[wr_addr] <= wr_lvl;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  value_ff  <= '0;
                  t_ff      <= (req_data.position > bet_pkg::ONE) ? bet_pkg::ONE
                                                                  : req_data.position;
                  case (req_data.op)
                     bet_pkg::OP_EVAL: begin
                        idx_ff    <= '0;
                        status_ff <= bet_pkg::ST_DONE;
                        state_ff  <= S_EVSCAN;
                     end
                     bet_pkg::OP_INSERT: begin
                        idx_ff <= '0;
                        k_ff   <= '0;
                        if (!ins_ok) begin
                           status_ff <= bet_pkg::ST_MARGIN;
                           state_ff  <= S_DONE;
                        end else if (used_ff == CNT_W'(bet_pkg::MAX_POINTS)) begin
                           status_ff <= bet_pkg::ST_FULL;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= bet_pkg::ST_DONE;
                           state_ff  <= S_INSFND;
                        end
                     end
                     bet_pkg::OP_REMOVE: begin
                        idx_ff     <= IDX_W'(1);
                        w_ff       <= IDX_W'(1);
                        removed_ff <= 1'b0;
                        if (!rem_ok) begin
                           status_ff <= bet_pkg::ST_MARGIN;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= bet_pkg::ST_DONE;
                           state_ff  <= S_REM;
                        end
                     end
                     default: begin
                        idx_ff    <= '0;
                        status_ff <= bet_pkg::ST_DONE;
                        state_ff  <= S_NUD0;
                     end
                  endcase
               end
            end
            S_EVSCAN: begin
               // first index at or past t, clamped to the last segment
               if (idx_ff == '0) begin
                  prev_p_ff <= rd_pos;
                  prev_l_ff <= rd_lvl;
                  idx_ff    <= IDX_W'(1);
               end else if (rd_pos >= t_ff || idx_ff == last_idx) begin
                  cur_p_ff <= rd_pos;
                  cur_l_ff <= rd_lvl;
                  state_ff <= S_EVMUL;
               end else begin
                  prev_p_ff <= rd_pos;
                  prev_l_ff <= rd_lvl;
                  idx_ff    <= idx_ff + IDX_W'(1);
               end
            end
            S_EVMUL: begin
               if (span_c == '0 || t_ff <= prev_p_ff) begin
                  value_ff <= prev_l_ff;
                  state_ff <= S_DONE;
               end else begin
                  // quotient fits DW bits, so the high half starts below span
                  rem_ff     <= prod_c[2*DW-1:DW];
                  low_ff     <= prod_c[DW-1:0];
                  span_ff    <= span_c;
                  neg_ff     <= cur_l_ff < prev_l_ff;
                  div_cnt_ff <= '0;
                  state_ff   <= S_EVDIV;
               end
            end
            S_EVDIV: begin
               if (trial >= {1'b0, span_ff}) begin
                  rem_ff <= DW'(trial - {1'b0, span_ff});
                  quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[DW-1:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
               low_ff     <= {low_ff[DW-2:0], 1'b0};
               div_cnt_ff <= div_cnt_ff + DIV_W'(1);
               if (div_cnt_ff == DIV_W'(DW - 1))
                  state_ff <= S_EVFIN;
            end
            S_EVFIN: begin
               value_ff <= fin_val;
               state_ff <= S_DONE;
            end
            S_INSFND: begin
               k_ff <= k_new;
               if (idx_ff == last_idx) begin
                  idx_ff   <= IDX_W'(used_ff);
                  state_ff <= S_INSSHF;
               end else
                  idx_ff <= idx_ff + IDX_W'(1);
            end
            S_INSSHF: begin
               if ({1'b0, idx_ff} <= {1'b0, k_ff} + (IDX_W+1)'(1)) begin
                  used_ff  <= used_ff + CNT_W'(1);
                  state_ff <= S_DONE;
               end else
                  idx_ff <= idx_ff - IDX_W'(1);
            end
            S_REM: begin
               // compaction: read at idx, write survivors at w
               if (idx_ff == last_idx) begin
                  used_ff   <= CNT_W'(w_ff) + CNT_W'(1);
                  status_ff <= removed_ff ? bet_pkg::ST_DONE : bet_pkg::ST_NO_REMOVE;
                  state_ff  <= S_DONE;
               end else begin
                  if (hit)
                     removed_ff <= 1'b1;
                  else
                     w_ff <= w_ff + IDX_W'(1);
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_NUD0: begin
               idx_ff   <= last_idx;
               state_ff <= S_NUD1;
            end
            S_NUD1: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.value        <= value_ff;
                  rsp_ff.point_count  <= used_ff;
                  rsp_ff.status       <= status_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
